// File: design/sagg_pkg.sv
// Shared types and constants for the allreduce slot aggregator.
// Used by the slot reduction, the lanes and the top level through scoped names.
package sagg_pkg;

  localparam int HALF_SLOTS_DEF = 16;
  localparam int CHILDREN_DEF   = 2;
  localparam int LANES_DEF      = 8;

  localparam int MAX_LANES = 8;
  localparam int DEG_W     = 5;
  localparam int PSN_W     = 24;
  localparam int CNT_W     = 4;
  localparam int CHILD_W   = 4;
  localparam int WORD_W    = 32;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_RD_S,
    ST_RD_SH,
    ST_WR_SH,
    ST_WR_S,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr;
  } lane_cmd_t;

endpackage

// File: design/sagg_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sagg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/sagg_slot_calc.sv
// Sequence number to slot reduction: psn mod (2*HALF_SLOTS) by reciprocal
// multiply, back-multiply and one correction, plus the shadow slot. Uses sagg_pkg.
module sagg_slot_calc #(
  parameter int HALF_SLOTS = sagg_pkg::HALF_SLOTS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [sagg_pkg::PSN_W-1:0]           psn,
  output logic                                 done,
  output logic [$clog2(2*HALF_SLOTS)-1:0]      slot,
  output logic [$clog2(2*HALF_SLOTS)-1:0]      shadow
);

  localparam int NUM_SLOTS = 2 * HALF_SLOTS;
  localparam int SW        = $clog2(NUM_SLOTS);
  localparam int PW        = sagg_pkg::PSN_W;
  // floor(2^32 / N) underestimates, so the quotient is low by at most one
  localparam logic [31:0] RECIP = 32'((64'd1 << 32) / NUM_SLOTS);

  logic          v1_r, v2_r, v3_r;
  logic [PW-1:0] q_r, p1_r, qn_r, p2_r;
  logic [SW-1:0] slot_r, shadow_r;

  logic [PW+31:0] prod_w;
  logic [PW+11:0] qn_w;
  logic [PW-1:0]  diff_w;
  logic [SW:0]    rem_w, s_w, sh_w;

  assign prod_w = {32'd0, psn} * {{PW{1'b0}}, RECIP};
  assign qn_w   = {12'd0, q_r} * (PW + 12)'(NUM_SLOTS);
  assign diff_w = p2_r - qn_r;
  assign rem_w  = diff_w[SW:0];
  assign s_w    = (rem_w >= (SW + 1)'(NUM_SLOTS)) ? rem_w - (SW + 1)'(NUM_SLOTS) : rem_w;
  assign sh_w   = (s_w < (SW + 1)'(HALF_SLOTS)) ? s_w + (SW + 1)'(HALF_SLOTS)
                                                : s_w - (SW + 1)'(HALF_SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // advance each stage only with its own item, so the slot holds until the next start
  always_ff @(posedge clk) begin
    if (start) begin
      q_r  <= prod_w[PW+31:32];
      p1_r <= psn;
    end
    if (v1_r) begin
      qn_r <= qn_w[PW-1:0];
      p2_r <= p1_r;
    end
    if (v2_r) begin
      slot_r   <= s_w[SW-1:0];
      shadow_r <= sh_w[SW-1:0];
    end
  end

  assign done   = v3_r;
  assign slot   = slot_r;
  assign shadow = shadow_r;

endmodule

// File: design/sagg_lane.sv
// One aggregation lane: per-slot word store and its 32-bit wrapping adder.
// Depends on sagg_pkg and sagg_ram.
module sagg_lane #(
  parameter int NUM_SLOTS = 2 * sagg_pkg::HALF_SLOTS_DEF
) (
  input  logic                         clk,
  input  sagg_pkg::lane_cmd_t          cmd,
  input  logic [$clog2(NUM_SLOTS)-1:0] rd_addr,
  input  logic [$clog2(NUM_SLOTS)-1:0] wr_addr,
  input  logic [sagg_pkg::WORD_W-1:0]  add_val,
  output logic [sagg_pkg::WORD_W-1:0]  old_word,
  output logic [sagg_pkg::WORD_W-1:0]  new_word
);

  logic [sagg_pkg::WORD_W-1:0] rdata;
  logic [sagg_pkg::WORD_W-1:0] wdata;

  // read data holds between reads, so the sum stays valid until the next item
  assign new_word = rdata + add_val;
  assign old_word = rdata;
  assign wdata    = cmd.clr ? '0 : new_word;

  sagg_ram #(
    .WIDTH(sagg_pkg::WORD_W),
    .DEPTH(NUM_SLOTS)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(wr_addr),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

endmodule

// File: design/allreduce_slot_aggregator.sv
// Top level of the allreduce slot aggregator: sequencer, slot metadata store,
// parallel sum lanes and result merge. Depends on sagg_pkg, sagg_ram,
// sagg_slot_calc and sagg_lane.
//
// Usage:
//   Input beat (in_valid/in_stall): one child's packet, psn and up to LANES
//   words. Result beat (out_valid/out_stall): completed slot sums, sent when
//   the slot's degree reaches CHILDREN (also on repeated arrivals).
//   cfg_valid/cfg_ready writes is_root; cfg_ready is always high.
//   An input beat passes through the psn-to-slot reduction (reciprocal
//   multiply, back-multiply, correction), then two metadata reads and two
//   writes on the single write port of each store, then the result load.
//   A new beat is taken only in idle, once the last item is through.
//   A beat from an out-of-range child is dropped in its accept cycle.
//   in_stall is high while an item is in work.
//   The result register lets the next item in while a result waits; when
//   the receiver stalls and a second result is ready, the sequencer holds.
//   After reset a clearing pass zeroes all stores, one slot per cycle,
//   over all 2*HALF_SLOTS slots with in_stall high; is_root returns to 1.
module allreduce_slot_aggregator #(
  parameter int HALF_SLOTS = sagg_pkg::HALF_SLOTS_DEF,
  parameter int CHILDREN   = sagg_pkg::CHILDREN_DEF,
  parameter int LANES      = sagg_pkg::LANES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_child,
  input  logic [23:0] in_psn,
  input  logic [3:0]  in_word_count,
  input  logic [31:0] in_value_0,
  input  logic [31:0] in_value_1,
  input  logic [31:0] in_value_2,
  input  logic [31:0] in_value_3,
  input  logic [31:0] in_value_4,
  input  logic [31:0] in_value_5,
  input  logic [31:0] in_value_6,
  input  logic [31:0] in_value_7,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [23:0] out_psn,
  output logic [3:0]  out_count,
  output logic        out_to_parent,
  output logic [31:0] out_sum_0,
  output logic [31:0] out_sum_1,
  output logic [31:0] out_sum_2,
  output logic [31:0] out_sum_3,
  output logic [31:0] out_sum_4,
  output logic [31:0] out_sum_5,
  output logic [31:0] out_sum_6,
  output logic [31:0] out_sum_7,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_is_root
);

  localparam int NUM_SLOTS = 2 * HALF_SLOTS;
  localparam int SW        = $clog2(NUM_SLOTS);
  localparam int DW        = sagg_pkg::DEG_W;
  localparam int MW        = CHILDREN + DW;
  localparam int ML        = sagg_pkg::MAX_LANES;
  localparam int WW        = sagg_pkg::WORD_W;
  localparam int CW        = sagg_pkg::CNT_W;

  sagg_pkg::state_t state_r, state_nxt;

  logic [SW-1:0] clr_r, clr_nxt;
  logic          is_root_r;

  logic [sagg_pkg::CHILD_W-1:0] child_r;
  logic [sagg_pkg::PSN_W-1:0]   psn_r;
  logic [CW-1:0]                cnt_r;
  logic [WW-1:0]                val_r [LANES];
  logic [MW-1:0]                meta_s_r;

  logic          out_valid_r;
  logic [23:0]   out_psn_r;
  logic [CW-1:0] out_count_r;
  logic          out_to_parent_r;
  logic [WW-1:0] out_sum_r [ML];

  logic [WW-1:0] in_value_w [ML];
  logic          accept, child_ok, calc_start, calc_done;
  logic [CW-1:0] cnt_sat;
  logic [SW-1:0] slot, shadow;

  logic          meta_we, meta_re;
  logic [SW-1:0] meta_waddr, meta_raddr, lane_waddr;
  logic [MW-1:0] meta_wdata, meta_rdata;

  logic [CHILDREN-1:0] bit_mask;
  logic                first;
  logic [DW-1:0]       deg_new;
  logic                emit, out_free, out_load;

  sagg_pkg::lane_cmd_t lane_cmd [LANES];
  logic [WW-1:0]       lane_old [LANES];
  logic [WW-1:0]       lane_new [LANES];
  logic [WW-1:0]       sum_pick [ML];

  assign in_value_w[0] = in_value_0;
  assign in_value_w[1] = in_value_1;
  assign in_value_w[2] = in_value_2;
  assign in_value_w[3] = in_value_3;
  assign in_value_w[4] = in_value_4;
  assign in_value_w[5] = in_value_5;
  assign in_value_w[6] = in_value_6;
  assign in_value_w[7] = in_value_7;

  assign accept     = in_valid && !in_stall;
  assign child_ok   = {1'b0, in_child} < (sagg_pkg::CHILD_W + 1)'(CHILDREN);
  assign calc_start = accept && child_ok;
  assign cnt_sat    = (in_word_count > CW'(LANES)) ? CW'(LANES) : in_word_count;
  assign cfg_ready  = 1'b1;

  assign bit_mask = CHILDREN'(1) << child_r;
  assign first    = (meta_s_r[MW-1:DW] & bit_mask) == '0;
  assign deg_new  = first ? meta_s_r[DW-1:0] + DW'(1) : meta_s_r[DW-1:0];
  assign emit     = deg_new == DW'(CHILDREN);
  assign out_free = !out_valid_r || !out_stall;

  sagg_slot_calc #(
    .HALF_SLOTS(HALF_SLOTS)
  ) u_slot_calc (
    .clk   (clk),
    .rst_n (rst_n),
    .start (calc_start),
    .psn   (in_psn),
    .done  (calc_done),
    .slot  (slot),
    .shadow(shadow)
  );

  // mask in the upper bits, degree in the lower bits
  sagg_ram #(
    .WIDTH(MW),
    .DEPTH(NUM_SLOTS)
  ) u_meta_ram (
    .clk  (clk),
    .we   (meta_we),
    .waddr(meta_waddr),
    .wdata(meta_wdata),
    .re   (meta_re),
    .raddr(meta_raddr),
    .rdata(meta_rdata)
  );

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    sagg_lane #(
      .NUM_SLOTS(NUM_SLOTS)
    ) u_lane (
      .clk     (clk),
      .cmd     (lane_cmd[i]),
      .rd_addr (slot),
      .wr_addr (lane_waddr),
      .add_val (val_r[i]),
      .old_word(lane_old[i]),
      .new_word(lane_new[i])
    );
  end

  // merge: pick updated or held sums, zero past the word count
  for (genvar i = 0; i < ML; i++) begin : g_pick
    if (i < LANES) begin : g_used
      assign sum_pick[i] = (CW'(i) < cnt_r) ? (first ? lane_new[i] : lane_old[i]) : '0;
    end else begin : g_unused
      assign sum_pick[i] = '0;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    case (state_r)
      sagg_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + SW'(1);
        if (clr_r == SW'(NUM_SLOTS - 1)) begin
          state_nxt = sagg_pkg::ST_IDLE;
        end
      end
      sagg_pkg::ST_IDLE: begin
        if (calc_start) begin
          state_nxt = sagg_pkg::ST_CALC;
        end
      end
      sagg_pkg::ST_CALC: begin
        if (calc_done) begin
          state_nxt = sagg_pkg::ST_RD_S;
        end
      end
      sagg_pkg::ST_RD_S:  state_nxt = sagg_pkg::ST_RD_SH;
      sagg_pkg::ST_RD_SH: state_nxt = sagg_pkg::ST_WR_SH;
      sagg_pkg::ST_WR_SH: state_nxt = sagg_pkg::ST_WR_S;
      sagg_pkg::ST_WR_S:  state_nxt = sagg_pkg::ST_EMIT;
      sagg_pkg::ST_EMIT: begin
        if (!emit || out_free) begin
          state_nxt = sagg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = sagg_pkg::ST_CLEAR;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall   = 1'b1;
    meta_we    = 1'b0;
    meta_re    = 1'b0;
    meta_waddr = slot;
    meta_raddr = slot;
    meta_wdata = '0;
    lane_waddr = slot;
    out_load   = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      lane_cmd[i] = '0;
    end
    case (state_r)
      sagg_pkg::ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_r;
        lane_waddr = clr_r;
        for (int i = 0; i < LANES; i++) begin
          lane_cmd[i].wr_en = 1'b1;
          lane_cmd[i].clr   = 1'b1;
        end
      end
      sagg_pkg::ST_IDLE: in_stall = 1'b0;
      sagg_pkg::ST_RD_S: begin
        meta_re = 1'b1;
        for (int i = 0; i < LANES; i++) begin
          lane_cmd[i].rd_en = 1'b1;
        end
      end
      sagg_pkg::ST_RD_SH: begin
        meta_re    = 1'b1;
        meta_raddr = shadow;
      end
      sagg_pkg::ST_WR_SH: begin
        // on a first arrival, drop this child from the shadow slot, zero its degree and zero its words
        meta_we    = first;
        meta_waddr = shadow;
        meta_wdata = {meta_rdata[MW-1:DW] & ~bit_mask, DW'(0)};
        lane_waddr = shadow;
        for (int i = 0; i < LANES; i++) begin
          lane_cmd[i].wr_en = first && (CW'(i) < cnt_r);
          lane_cmd[i].clr   = 1'b1;
        end
      end
      sagg_pkg::ST_WR_S: begin
        meta_we    = first;
        meta_wdata = {meta_s_r[MW-1:DW] | bit_mask, deg_new};
        for (int i = 0; i < LANES; i++) begin
          lane_cmd[i].wr_en = first && (CW'(i) < cnt_r);
        end
      end
      sagg_pkg::ST_EMIT: out_load = emit && out_free;
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sagg_pkg::ST_CLEAR;
      clr_r     <= '0;
      is_root_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      if (cfg_valid && cfg_ready) begin
        is_root_r <= cfg_is_root;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      child_r <= in_child;
      psn_r   <= in_psn;
      cnt_r   <= cnt_sat;
      for (int i = 0; i < LANES; i++) begin
        val_r[i] <= in_value_w[i];
      end
    end
    if (state_r == sagg_pkg::ST_RD_SH) begin
      meta_s_r <= meta_rdata;
    end
  end

  // result register: hold while stalled, reload from the merge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_psn_r       <= psn_r;
      out_count_r     <= cnt_r;
      out_to_parent_r <= !is_root_r;
      for (int i = 0; i < ML; i++) begin
        out_sum_r[i] <= sum_pick[i];
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_psn       = out_psn_r;
  assign out_count     = out_count_r;
  assign out_to_parent = out_to_parent_r;
  assign out_sum_0     = out_sum_r[0];
  assign out_sum_1     = out_sum_r[1];
  assign out_sum_2     = out_sum_r[2];
  assign out_sum_3     = out_sum_r[3];
  assign out_sum_4     = out_sum_r[4];
  assign out_sum_5     = out_sum_r[5];
  assign out_sum_6     = out_sum_r[6];
  assign out_sum_7     = out_sum_r[7];

`ifndef SYNTHESIS
  a_clear_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == sagg_pkg::ST_CLEAR && clr_r != SW'(NUM_SLOTS - 1))
      |=> state_r == sagg_pkg::ST_CLEAR)
    else $error("clearing pass ended early");

  a_calc_owner: assert property (@(posedge clk) disable iff (!rst_n)
    calc_done |-> state_r == sagg_pkg::ST_CALC)
    else $error("slot reduction finished outside its wait state");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sagg_pkg::ST_RD_S
      |-> ({1'b0, slot} < (SW + 1)'(NUM_SLOTS)) && (slot != shadow))
    else $error("slot or shadow slot out of range");

  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == sagg_pkg::ST_EMIT)
    else $error("result loaded outside the emit step");
`endif

endmodule
